// ===== design/vass_pkg.sv =====
`timescale 1ns / 1ps
package vass_pkg;

	localparam int ARRAY_LENGTH  = 256;
	localparam int LOG_DEPTH     = 16;
	localparam int SNAPSHOT_BITS = 16;
	localparam int VALUE_BITS    = 32;

	localparam int ROW_W   = (ARRAY_LENGTH > 1) ? $clog2(ARRAY_LENGTH) : 1;
	localparam int PTR_W   = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int CNT_W   = $clog2(LOG_DEPTH + 1);
	localparam int LOG_ENTRIES = ARRAY_LENGTH * LOG_DEPTH;
	localparam int LADDR_W = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
	localparam int CMP_W   = (SNAPSHOT_BITS > 16) ? SNAPSHOT_BITS : 16;

	localparam logic [SNAPSHOT_BITS-1:0] SNAP_MAX = '1;

	typedef enum logic [1:0] {
		ACT_SET  = 2'd0,
		ACT_SNAP = 2'd1,
		ACT_GET  = 2'd2,
		ACT_NOP  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	typedef struct packed {
		logic [SNAPSHOT_BITS-1:0] id;
		logic [VALUE_BITS-1:0]    value;
	} log_entry_t;

	// sign-extend from the stored width, then cut to the port width
	function automatic logic [31:0] widen_value(input logic [VALUE_BITS-1:0] v);
		return 32'(signed'(v));
	endfunction

	function automatic logic [LADDR_W-1:0] log_addr(input logic [ROW_W-1:0] row,
		input logic [PTR_W-1:0] ptr);
		return LADDR_W'(int'(row) * LOG_DEPTH + int'(ptr));
	endfunction

endpackage

// ===== design/vass_req_if.sv =====
`timescale 1ns / 1ps
interface vass_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [7:0]         index;
	logic signed [31:0] write_value;
	logic [15:0]        query_snapshot;

	modport source (output valid, action, index, write_value, query_snapshot, input ready);
	modport sink (input valid, action, index, write_value, query_snapshot, output ready);
endinterface

// ===== design/vass_rsp_if.sv =====
`timescale 1ns / 1ps
interface vass_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] read_value;
	logic [15:0]        snapshot_taken;
	logic [1:0]         status;

	modport source (output valid, read_value, snapshot_taken, status, input ready);
	modport sink (input valid, read_value, snapshot_taken, status, output ready);
endinterface

// ===== design/vass_ram.sv =====
`timescale 1ns / 1ps
module vass_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/versioned_array_snapshot_store.sv =====
`timescale 1ns / 1ps
// Versioned array with snapshots. Each array position keeps a log of
// (snapshot id, value) entries in a log RAM; a count RAM holds each log's fill.
// req channel: one beat carries action (set, snap, get, no-op), index,
// write_value and query_snapshot. rsp channel: one beat per request with
// read_value, snapshot_taken and status, in request order.
// Steps per request, from accept to the done state:
//   snap, no-op or out-of-range index: straight to the done state
//   set: count read, newest entry read, write back; no entry read if log empty
//   get: count read, k binary search probes, at most floor(log2(LOG_DEPTH)) + 1
//        (5 for 16 entries); one read of the single log RAM port per probe.
// The done state loads the response into the output register; req.ready
// comes back as the response appears, so the next request is taken while the
// response waits in the output register. When rsp stalls with a response
// held, a finished second request waits in its last state.
// Reset clears the snapshot counter and the per-position valid bits that
// stand in for a zeroed count RAM; no clearing pass is needed, and req is
// ready in the first cycle after reset.
module versioned_array_snapshot_store (
	input logic        clk,
	input logic        arst_n,
	vass_req_if.sink   req,
	vass_rsp_if.source rsp
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_CNT    = 5'b00010,
		S_SETCHK = 5'b00100,
		S_CMP    = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t                             state_q, state_d;
	logic [1:0]                         act_q;
	logic [vass_pkg::ROW_W-1:0]         row_q;
	logic [vass_pkg::VALUE_BITS-1:0]    wval_q;
	logic [15:0]                        qry_q;
	logic [vass_pkg::CNT_W-1:0]         cnt_q, cnt_d;
	logic [vass_pkg::CNT_W-1:0]         lo_q, lo_d, hi_q, hi_d;
	logic [vass_pkg::PTR_W-1:0]         mid_q, mid_d;
	logic [31:0]                        ans_q, ans_d;
	logic [15:0]                        taken_q, taken_d;
	logic [1:0]                         status_q, status_d;
	logic [vass_pkg::SNAPSHOT_BITS-1:0] cur_snap_q, cur_snap_d;
	logic [vass_pkg::ARRAY_LENGTH-1:0]  valid_q;

	logic                               out_valid_q;
	logic [31:0]                        out_rv_q;
	logic [15:0]                        out_taken_q;
	logic [1:0]                         out_status_q;

	logic                               accept;
	logic                               in_range;
	logic                               out_load;
	logic [vass_pkg::CNT_W-1:0]         cnt_cur;

	logic                               cnt_we;
	logic [vass_pkg::ROW_W-1:0]         cnt_raddr;
	logic [vass_pkg::CNT_W-1:0]         cnt_wdata, cnt_rdata;
	logic                               log_we;
	logic [vass_pkg::LADDR_W-1:0]       log_waddr, log_raddr;
	vass_pkg::log_entry_t               log_wdata, log_rdata;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_range  = (32'(req.index) < 32'(vass_pkg::ARRAY_LENGTH));
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
	assign cnt_raddr = (state_q == S_IDLE) ? vass_pkg::ROW_W'(req.index) : row_q;
	assign cnt_cur   = valid_q[row_q] ? cnt_rdata : '0;

	vass_ram #(
		.WIDTH(vass_pkg::CNT_W),
		.DEPTH(vass_pkg::ARRAY_LENGTH)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(row_q),
		.wdata(cnt_wdata),
		.raddr(cnt_raddr),
		.rdata(cnt_rdata)
	);

	vass_ram #(
		.WIDTH($bits(vass_pkg::log_entry_t)),
		.DEPTH(vass_pkg::LOG_ENTRIES)
	) u_log_ram (
		.clk  (clk),
		.we   (log_we),
		.waddr(log_waddr),
		.wdata(log_wdata),
		.raddr(log_raddr),
		.rdata(log_rdata)
	);

	always_comb begin
		logic [vass_pkg::CNT_W-1:0] lo_n, hi_n, mid_n;
		lo_n = '0;
		hi_n = '0;
		mid_n = '0;
		state_d    = state_q;
		cnt_d      = cnt_q;
		lo_d       = lo_q;
		hi_d       = hi_q;
		mid_d      = mid_q;
		ans_d      = ans_q;
		taken_d    = taken_q;
		status_d   = status_q;
		cur_snap_d = cur_snap_q;
		cnt_we     = 1'b0;
		cnt_wdata  = '0;
		log_we     = 1'b0;
		log_waddr  = '0;
		log_wdata  = '0;
		log_raddr  = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					ans_d    = '0;
					taken_d  = '0;
					status_d = vass_pkg::ST_OK;
					state_d  = S_DONE;
					if (req.action == vass_pkg::ACT_SNAP) begin
						taken_d = 16'(cur_snap_q);
						if (cur_snap_q == vass_pkg::SNAP_MAX) begin
							status_d = vass_pkg::ST_SAT;
						end else begin
							cur_snap_d = cur_snap_q + 1'b1;
						end
					end else if ((req.action == vass_pkg::ACT_SET ||
						req.action == vass_pkg::ACT_GET) && in_range) begin
						state_d = S_CNT;
					end
				end
			end
			S_CNT: begin
				cnt_d = cnt_cur;
				if (act_q == vass_pkg::ACT_SET) begin
					if (cnt_cur == '0) begin
						// empty log: append first entry
						log_we    = 1'b1;
						log_waddr = vass_pkg::log_addr(row_q, '0);
						log_wdata = '{id: cur_snap_q, value: wval_q};
						cnt_we    = 1'b1;
						cnt_wdata = vass_pkg::CNT_W'(1);
						state_d   = S_DONE;
					end else begin
						log_raddr = vass_pkg::log_addr(row_q,
							vass_pkg::PTR_W'(cnt_cur - 1'b1));
						state_d   = S_SETCHK;
					end
				end else begin
					lo_d = '0;
					hi_d = cnt_cur;
					if (cnt_cur == '0) begin
						state_d = S_DONE;
					end else begin
						mid_d     = vass_pkg::PTR_W'(cnt_cur >> 1);
						log_raddr = vass_pkg::log_addr(row_q, vass_pkg::PTR_W'(cnt_cur >> 1));
						state_d   = S_CMP;
					end
				end
			end
			S_SETCHK: begin
				state_d = S_DONE;
				if (log_rdata.id == cur_snap_q) begin
					// newest entry is from this snapshot: overwrite in place
					log_we    = 1'b1;
					log_waddr = vass_pkg::log_addr(row_q, vass_pkg::PTR_W'(cnt_q - 1'b1));
					log_wdata = '{id: cur_snap_q, value: wval_q};
				end else if (cnt_q >= vass_pkg::CNT_W'(vass_pkg::LOG_DEPTH)) begin
					status_d = vass_pkg::ST_FULL;
				end else begin
					log_we    = 1'b1;
					log_waddr = vass_pkg::log_addr(row_q, vass_pkg::PTR_W'(cnt_q));
					log_wdata = '{id: cur_snap_q, value: wval_q};
					cnt_we    = 1'b1;
					cnt_wdata = cnt_q + 1'b1;
				end
			end
			S_CMP: begin
				lo_n = lo_q;
				hi_n = hi_q;
				if (vass_pkg::CMP_W'(log_rdata.id) <= vass_pkg::CMP_W'(qry_q)) begin
					ans_d = vass_pkg::widen_value(log_rdata.value);
					lo_n  = vass_pkg::CNT_W'(mid_q) + 1'b1;
				end else begin
					hi_n = vass_pkg::CNT_W'(mid_q);
				end
				lo_d = lo_n;
				hi_d = hi_n;
				if (lo_n < hi_n) begin
					mid_n     = lo_n + ((hi_n - lo_n) >> 1);
					mid_d     = vass_pkg::PTR_W'(mid_n);
					log_raddr = vass_pkg::log_addr(row_q, vass_pkg::PTR_W'(mid_n));
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_snap_q  <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cur_snap_q <= cur_snap_d;
			if (cnt_we) begin
				valid_q[row_q] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= req.action;
			row_q  <= vass_pkg::ROW_W'(req.index);
			wval_q <= vass_pkg::VALUE_BITS'(req.write_value);
			qry_q  <= req.query_snapshot;
		end
		cnt_q    <= cnt_d;
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		mid_q    <= mid_d;
		ans_q    <= ans_d;
		taken_q  <= taken_d;
		status_q <= status_d;
		if (out_load) begin
			out_rv_q     <= ans_q;
			out_taken_q  <= taken_q;
			out_status_q <= status_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.read_value     = out_rv_q;
	assign rsp.snapshot_taken = out_taken_q;
	assign rsp.status         = out_status_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |-> (cnt_wdata != '0) && (cnt_wdata <= vass_pkg::CNT_W'(vass_pkg::LOG_DEPTH)))
		else $error("log count written out of range");

	a_write_only_on_set: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_we || log_we) |-> (act_q == vass_pkg::ACT_SET))
		else $error("store written by a non-set request");

	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |->
		(vass_pkg::CNT_W'(mid_q) >= lo_q) && (vass_pkg::CNT_W'(mid_q) < hi_q))
		else $error("search probe outside its window");

	a_snap_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (cur_snap_q >= $past(cur_snap_q)))
		else $error("snapshot counter went backward");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == S_DONE))
		else $error("response raised outside the done state");

endmodule
